[src/brt_pkg.sv]
// brt_pkg: shared types, codes and defaults for the block reassembly tracker.
// Used by block_reassembly_tracker_unit; no dependencies.
package brt_pkg;

  localparam int DEF_SLOTS        = 8;
  localparam int DEF_MAX_SUBBANDS = 64;

  localparam int BLK_W      = 32;
  localparam int SB_W       = 6;
  localparam int MASK_W     = 64;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int SPB_W      = 7;
  localparam int MIF_W      = 4;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_RELEASED = 3'd0;
  localparam kind_t KIND_ACCEPTED = 3'd1;
  localparam kind_t KIND_LATE     = 3'd2;
  localparam kind_t KIND_END      = 3'd3;
  localparam kind_t KIND_ERROR    = 3'd4;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIF = 1'd1;

  localparam logic [SPB_W-1:0] SPB_RESET = 7'd64;
  localparam logic [MIF_W-1:0] MIF_RESET = 4'd8;

  typedef enum logic [1:0] {
    SM_LOOKUP  = 2'd0,
    SM_RELEASE = 2'd1,
    SM_FLUSH   = 2'd2
  } scan_mode_t;

endpackage

[src/brt_ram.sv]
// brt_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module brt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/block_reassembly_tracker_unit.sv]
// block_reassembly_tracker_unit: top level of the block reassembly tracker.
// Depends on brt_pkg and brt_ram.
//
// Tracks up to SLOTS partly received blocks, each entry {block, mask, remaining}
// held in one slot RAM with a registered read; valid bits sit in flops. Every
// lookup and every in-order release walks the slot RAM one entry per cycle,
// so the slot RAM read port sets the pace and items are taken one at a time.
// in_stall is high while an item is in work. The result register lets a new
// item be taken while the last result waits.
module block_reassembly_tracker_unit #(
  parameter int SLOTS        = brt_pkg::DEF_SLOTS,
  parameter int MAX_SUBBANDS = brt_pkg::DEF_MAX_SUBBANDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [brt_pkg::BLK_W-1:0]     in_block_index,
  input  logic [brt_pkg::SB_W-1:0]      in_subband_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brt_pkg::KIND_W-1:0]    out_kind,
  output logic [brt_pkg::BLK_W-1:0]     out_released_block,
  output logic [brt_pkg::MASK_W-1:0]    out_received_mask,
  output logic                          out_last
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int MS  = MAX_SUBBANDS;
  localparam int RW  = $clog2(MAX_SUBBANDS + 1);
  localparam int BW  = brt_pkg::BLK_W;
  localparam int EW  = BW + MS + RW;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_DECIDE  = 8'b0000_0100,
    S_EVICT   = 8'b0000_1000,
    S_ALLOC   = 8'b0001_0000,
    S_UPDATE  = 8'b0010_0000,
    S_RELEASE = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  brt_pkg::scan_mode_t mode_r, mode_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [BW-1:0]       last_rel_r, last_rel_nxt;
  logic                any_rel_r, any_rel_nxt;
  logic [brt_pkg::SPB_W-1:0] spb_r;
  logic [brt_pkg::MIF_W-1:0] mif_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                match_hit_r, match_hit_nxt;
  logic                min_hit_r, min_hit_nxt;
  logic                out_valid_r, out_valid_nxt;

  // item and scan payload
  logic [BW-1:0]       blk_r, blk_nxt;
  logic [brt_pkg::SB_W-1:0] sb_r, sb_nxt;
  brt_pkg::kind_t      pend_kind_r, pend_kind_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]       match_idx_r, match_idx_nxt;
  logic [MS-1:0]       match_mask_r, match_mask_nxt;
  logic [RW-1:0]       match_rem_r, match_rem_nxt;
  logic [IW-1:0]       min_idx_r, min_idx_nxt;
  logic [BW-1:0]       min_blk_r, min_blk_nxt;
  logic [MS-1:0]       min_mask_r, min_mask_nxt;
  logic [IW-1:0]       cur_idx_r, cur_idx_nxt;
  logic [MS-1:0]       cur_mask_r, cur_mask_nxt;
  logic [RW-1:0]       cur_rem_r, cur_rem_nxt;
  brt_pkg::kind_t      out_kind_r, out_kind_nxt;
  logic [BW-1:0]       out_blk_r, out_blk_nxt;
  logic [brt_pkg::MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic                out_last_r, out_last_nxt;

  // slot RAM
  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;
  logic [BW-1:0]       rd_blk;
  logic [MS-1:0]       rd_mask;
  logic [RW-1:0]       rd_rem;

  // derived
  logic [brt_pkg::SPB_W-1:0] spb_clamp;
  logic [RW-1:0]       spb_eff;
  logic [7:0]          lim_eff;
  logic [7:0]          count8;
  logic                drop;
  logic                late;
  logic [IW-1:0]       free_idx;
  logic                in_xfer;
  logic                can_emit;
  logic [MS-1:0]       sb_bit;
  logic [MS-1:0]       upd_mask;
  logic [RW-1:0]       upd_rem;
  logic                rel_last;

  brt_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_blk  = ram_rdata[EW-1 -: BW];
  assign rd_mask = ram_rdata[RW +: MS];
  assign rd_rem  = ram_rdata[RW-1:0];

  assign spb_clamp = (spb_r == '0) ? 7'd1 :
                     (spb_r > 7'(MAX_SUBBANDS)) ? 7'(MAX_SUBBANDS) : spb_r;
  assign spb_eff   = RW'(spb_clamp);
  assign drop      = (mif_r != '0);
  assign lim_eff   = ({4'd0, mif_r} > 8'(SLOTS)) ? 8'(SLOTS) : {4'd0, mif_r};
  assign count8    = 8'($countones(valid_r));
  assign late      = any_rel_r && (blk_r <= last_rel_r);
  assign in_xfer   = in_valid && !in_stall;
  assign can_emit  = !out_valid_r || !out_stall;
  assign sb_bit    = MS'(1) << sb_r;
  assign rel_last  = (min_blk_r == blk_r);

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    upd_mask = cur_mask_r;
    upd_rem  = cur_rem_r;
    if ((cur_mask_r & sb_bit) == '0) begin
      upd_mask = cur_mask_r | sb_bit;
      if (cur_rem_r != '0) begin
        upd_rem = cur_rem_r - RW'(1);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    valid_nxt      = valid_r;
    last_rel_nxt   = last_rel_r;
    any_rel_nxt    = any_rel_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    match_hit_nxt  = match_hit_r;
    match_idx_nxt  = match_idx_r;
    match_mask_nxt = match_mask_r;
    match_rem_nxt  = match_rem_r;
    min_hit_nxt    = min_hit_r;
    min_idx_nxt    = min_idx_r;
    min_blk_nxt    = min_blk_r;
    min_mask_nxt   = min_mask_r;
    blk_nxt        = blk_r;
    sb_nxt         = sb_r;
    pend_kind_nxt  = pend_kind_r;
    cur_idx_nxt    = cur_idx_r;
    cur_mask_nxt   = cur_mask_r;
    cur_rem_nxt    = cur_rem_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_blk_nxt    = out_blk_r;
    out_mask_nxt   = out_mask_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_idx_r;
    ram_wdata      = {blk_r, upd_mask, upd_rem};
    ram_re         = 1'b0;
    ram_raddr      = cnt_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          blk_nxt = in_block_index;
          sb_nxt  = in_subband_index;
          cnt_nxt = '0;
          match_hit_nxt = 1'b0;
          min_hit_nxt   = 1'b0;
          if (in_operation == brt_pkg::OP_FINISH) begin
            mode_nxt  = brt_pkg::SM_FLUSH;
            state_nxt = S_SCAN;
          end else if ({1'b0, in_subband_index} >= spb_clamp) begin
            pend_kind_nxt = brt_pkg::KIND_ERROR;
            state_nxt     = S_EMIT;
          end else begin
            mode_nxt  = brt_pkg::SM_LOOKUP;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r != CW'(SLOTS)) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IW-1:0];
        end
        if (rd_vld_r && valid_r[rd_idx_r]) begin
          if (rd_blk == blk_r) begin
            match_hit_nxt  = 1'b1;
            match_idx_nxt  = rd_idx_r;
            match_mask_nxt = rd_mask;
            match_rem_nxt  = rd_rem;
          end
          if (!min_hit_r || rd_blk < min_blk_r) begin
            min_hit_nxt  = 1'b1;
            min_idx_nxt  = rd_idx_r;
            min_blk_nxt  = rd_blk;
            min_mask_nxt = rd_mask;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SLOTS)) begin
          state_nxt = (mode_r == brt_pkg::SM_LOOKUP) ? S_DECIDE : S_RELEASE;
        end
      end
      S_DECIDE: begin
        if (match_hit_r) begin
          cur_idx_nxt  = match_idx_r;
          cur_mask_nxt = match_mask_r;
          cur_rem_nxt  = match_rem_r;
          state_nxt    = S_UPDATE;
        end else if (late) begin
          pend_kind_nxt = drop ? brt_pkg::KIND_LATE : brt_pkg::KIND_ERROR;
          state_nxt     = S_EMIT;
        end else if (drop && count8 >= lim_eff) begin
          state_nxt = S_EVICT;
        end else if (!drop && count8 >= 8'(SLOTS)) begin
          pend_kind_nxt = brt_pkg::KIND_ERROR;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_EVICT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = brt_pkg::KIND_RELEASED;
          out_blk_nxt   = min_blk_r;
          out_mask_nxt  = brt_pkg::MASK_W'(min_mask_r);
          out_last_nxt  = 1'b0;
          valid_nxt[min_idx_r] = 1'b0;
          last_rel_nxt  = min_blk_r;
          any_rel_nxt   = 1'b1;
          state_nxt     = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cur_idx_nxt  = free_idx;
        cur_mask_nxt = '0;
        cur_rem_nxt  = spb_eff;
        state_nxt    = S_UPDATE;
      end
      S_UPDATE: begin
        ram_we = 1'b1;
        valid_nxt[cur_idx_r] = 1'b1;
        if (upd_rem == '0) begin
          mode_nxt      = brt_pkg::SM_RELEASE;
          cnt_nxt       = '0;
          match_hit_nxt = 1'b0;
          min_hit_nxt   = 1'b0;
          state_nxt     = S_SCAN;
        end else begin
          pend_kind_nxt = brt_pkg::KIND_ACCEPTED;
          state_nxt     = S_EMIT;
        end
      end
      S_RELEASE: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (mode_r == brt_pkg::SM_FLUSH && !min_hit_r) begin
            out_kind_nxt = brt_pkg::KIND_END;
            out_blk_nxt  = '0;
            out_mask_nxt = '0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_kind_nxt  = brt_pkg::KIND_RELEASED;
            out_blk_nxt   = min_blk_r;
            out_mask_nxt  = brt_pkg::MASK_W'(min_mask_r);
            valid_nxt[min_idx_r] = 1'b0;
            last_rel_nxt  = min_blk_r;
            any_rel_nxt   = 1'b1;
            cnt_nxt       = '0;
            match_hit_nxt = 1'b0;
            min_hit_nxt   = 1'b0;
            if (mode_r == brt_pkg::SM_RELEASE && rel_last) begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              out_last_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
          end
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_blk_nxt   = '0;
          out_mask_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= brt_pkg::SM_LOOKUP;
      valid_r     <= '0;
      last_rel_r  <= '0;
      any_rel_r   <= 1'b0;
      spb_r       <= brt_pkg::SPB_RESET;
      mif_r       <= brt_pkg::MIF_RESET;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      match_hit_r <= 1'b0;
      min_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      valid_r     <= valid_nxt;
      last_rel_r  <= last_rel_nxt;
      any_rel_r   <= any_rel_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      match_hit_r <= match_hit_nxt;
      min_hit_r   <= min_hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == brt_pkg::CFG_SPB) begin
        spb_r <= cfg_data;
      end
      if (cfg_we && cfg_index == brt_pkg::CFG_MIF) begin
        mif_r <= cfg_data[brt_pkg::MIF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r        <= blk_nxt;
    sb_r         <= sb_nxt;
    pend_kind_r  <= pend_kind_nxt;
    rd_idx_r     <= rd_idx_nxt;
    match_idx_r  <= match_idx_nxt;
    match_mask_r <= match_mask_nxt;
    match_rem_r  <= match_rem_nxt;
    min_idx_r    <= min_idx_nxt;
    min_blk_r    <= min_blk_nxt;
    min_mask_r   <= min_mask_nxt;
    cur_idx_r    <= cur_idx_nxt;
    cur_mask_r   <= cur_mask_nxt;
    cur_rem_r    <= cur_rem_nxt;
    out_kind_r   <= out_kind_nxt;
    out_blk_r    <= out_blk_nxt;
    out_mask_r   <= out_mask_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_released_block = out_blk_r;
  assign out_received_mask  = out_mask_r;
  assign out_last           = out_last_r;

  // a pending release always matches the last-released bookkeeping
  a_rel_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == brt_pkg::KIND_RELEASED |->
      any_rel_r && last_rel_r == out_blk_r)
    else $error("released block does not match last_released");

  // non-release results carry no block and no mask, and always set last
  a_nonrel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != brt_pkg::KIND_RELEASED |->
      out_blk_r == '0 && out_mask_r == '0 && out_last_r)
    else $error("non-release result with payload or without last");

  // eviction only runs with a found oldest slot that is still held
  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVICT |-> min_hit_r && valid_r[min_idx_r])
    else $error("eviction without a held oldest slot");

  // slot RAM is never written while a scan reads it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re && !rd_vld_r)
    else $error("slot RAM write overlaps a scan");

  // the slot written in S_UPDATE is marked valid
  a_update_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPDATE |=> valid_r[$past(cur_idx_r)])
    else $error("updated slot not marked valid");

endmodule

[tb/sv/block_reassembly_tracker_unit_tb.sv]
// Testbench for block_reassembly_tracker_unit: a directed table and random phases,
// with every result checked against a cycle-free prediction of the slot table or a pinned kind.
// Depends on brt_pkg and the tracker RTL.
`timescale 1ns / 100ps

module block_reassembly_tracker_unit_tb;
  import brt_pkg::*;

  localparam int SLOTS        = DEF_SLOTS;
  localparam int MAX_SB       = DEF_MAX_SUBBANDS;
  localparam int SETTLE_CYC   = SLOTS + 8;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYC     = 300;

  typedef struct packed {
    kind_t             kind;
    logic [BLK_W-1:0]  blk;
    logic [MASK_W-1:0] mask;
    logic              last;
  } tracker_result_t;

  typedef enum logic [1:0] {STEP_ITEM, STEP_SPB, STEP_MIF} step_t;

  typedef struct {
    step_t            step;
    logic             op;
    logic [BLK_W-1:0] blk;
    logic [SB_W-1:0]  sb;
    logic             pinned;
    kind_t            kind;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = OP_ADD;
  logic [BLK_W-1:0]      in_block_index = '0;
  logic [SB_W-1:0]       in_subband_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kind_t                 out_kind;
  logic [BLK_W-1:0]      out_released_block;
  logic [MASK_W-1:0]     out_received_mask;
  logic                  out_last;

  block_reassembly_tracker_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_block_index     (in_block_index),
    .in_subband_index   (in_subband_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_released_block (out_released_block),
    .out_received_mask  (out_received_mask),
    .out_last           (out_last)
  );

  always #1 clk = ~clk;

  // predicted slot table and registers
  logic [SPB_W-1:0]  sb_count_reg = SPB_RESET;
  logic [MIF_W-1:0]  flight_cap_reg = MIF_RESET;
  logic              held [SLOTS] = '{default: 1'b0};
  logic [BLK_W-1:0]  held_blk [SLOTS];
  logic [MASK_W-1:0] held_mask [SLOTS];
  logic [SPB_W-1:0]  held_left [SLOTS];
  logic [BLK_W-1:0]  newest_out = '0;
  logic              released_any = 1'b0;

  tracker_result_t burst[$];
  tracker_result_t pending_results[$];
  plan_row_t       plan[$];
  tracker_result_t oldest_due;

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [BLK_W-1:0] next_blk = 32'd200;

  function automatic int oldest_held();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (held[i] && (best < 0 || held_blk[i] < held_blk[best])) best = i;
    return best;
  endfunction

  function automatic void note(kind_t k, logic [BLK_W-1:0] b, logic [MASK_W-1:0] m);
    tracker_result_t r;
    r.kind = k;
    r.blk  = b;
    r.mask = m;
    r.last = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void free_slot(int s);
    note(KIND_RELEASED, held_blk[s], held_mask[s]);
    newest_out   = held_blk[s];
    released_any = 1'b1;
    held[s]      = 1'b0;
  endfunction

  // computes the results of one accepted item into burst and updates the table
  function automatic void reassemble(logic op, logic [BLK_W-1:0] blk, logic [SB_W-1:0] sb);
    int              s, m, count;
    int unsigned     eff, cap;
    logic            drop;
    logic [MASK_W-1:0] bitv;
    tracker_result_t r;
    burst.delete();
    eff = (sb_count_reg == 0) ? 1 : ((sb_count_reg > MAX_SB) ? MAX_SB : sb_count_reg);
    cap = (flight_cap_reg > SLOTS) ? SLOTS : flight_cap_reg;
    drop = (flight_cap_reg != 0);
    s = -1;
    if (op == OP_FINISH) begin
      m = oldest_held();
      while (m >= 0) begin
        free_slot(m);
        m = oldest_held();
      end
      note(KIND_END, '0, '0);
    end else if (sb >= eff) begin
      note(KIND_ERROR, '0, '0);
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (held[i] && held_blk[i] == blk) s = i;
      if (s < 0) begin
        count = 0;
        for (int i = 0; i < SLOTS; i++)
          if (held[i]) count++;
        if (released_any && blk <= newest_out) begin
          note(drop ? KIND_LATE : KIND_ERROR, '0, '0);
        end else if (!drop && count >= SLOTS) begin
          note(KIND_ERROR, '0, '0);
        end else begin
          if (drop && count >= cap) free_slot(oldest_held());
          for (int i = 0; i < SLOTS; i++)
            if (!held[i] && s < 0) s = i;
          held[s]      = 1'b1;
          held_blk[s]  = blk;
          held_mask[s] = '0;
          held_left[s] = eff[SPB_W-1:0];
        end
      end
      if (s >= 0) begin
        bitv = 64'd1 << sb;
        if ((held_mask[s] & bitv) == 0) begin
          held_mask[s] = held_mask[s] | bitv;
          if (held_left[s] != 0) held_left[s] = held_left[s] - 1'b1;
        end
        if (held_left[s] == 0) begin
          m = oldest_held();
          while (m >= 0 && held_blk[m] <= blk) begin
            free_slot(m);
            m = oldest_held();
          end
        end else begin
          note(KIND_ACCEPTED, '0, '0);
        end
      end
    end
    r = burst.pop_back();
    r.last = 1'b1;
    burst.push_back(r);
  endfunction

  function automatic void plan_row(step_t st, logic op, logic [BLK_W-1:0] blk,
                                   logic [SB_W-1:0] sb, logic pin, kind_t k);
    plan_row_t p;
    p.step   = st;
    p.op     = op;
    p.blk    = blk;
    p.sb     = sb;
    p.pinned = pin;
    p.kind   = k;
    plan.push_back(p);
  endfunction

  function automatic void check_field(string name, logic [MASK_W-1:0] want,
                                      logic [MASK_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  task automatic send(logic op, logic [BLK_W-1:0] blk, logic [SB_W-1:0] sb,
                      logic pinned, kind_t kind);
    tracker_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_block_index   <= blk;
    in_subband_index <= sb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reassemble(op, blk, sb);
    if (pinned) begin
      r.kind = kind;
      r.blk  = '0;
      r.mask = '0;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (burst[i]) pending_results.push_back(burst[i]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == CFG_SPB) sb_count_reg = data[SPB_W-1:0];
    else flight_cap_reg = data[MIF_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int n);
    logic            op;
    logic [BLK_W-1:0] blk;
    logic [SB_W-1:0] sb;
    logic [BLK_W:0]  wide;
    int unsigned     r, eff;
    for (int k = 0; k < n; k++) begin
      eff  = (sb_count_reg == 0) ? 1 : ((sb_count_reg > MAX_SB) ? MAX_SB : sb_count_reg);
      r    = $urandom_range(99);
      op   = OP_ADD;
      wide = {1'b0, next_blk} + $urandom_range(5);
      blk  = wide[BLK_W] ? '1 : wide[BLK_W-1:0];
      sb   = $urandom_range(eff - 1, 0);
      if (r < 6) begin
        op  = OP_FINISH;
        blk = $urandom;
        sb  = $urandom;
      end else if (r < 11 && released_any) begin
        blk = $urandom_range(newest_out, 0);
      end else if (r < 15) begin
        sb = $urandom;
      end
      send(op, blk, sb, 1'b0, KIND_ERROR);
      if (released_any && newest_out >= next_blk && newest_out != '1)
        next_blk = newest_out + 1;
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall,
                           logic [CFG_DATA_W-1:0] spb, logic [CFG_DATA_W-1:0] mif, int n);
    settle();
    idle_pct  = idle;
    stall_pct = stall;
    write_reg(CFG_SPB, spb);
    write_reg(CFG_MIF, mif);
    random_items(n);
  endtask

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYC;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    if (hold_left != 0) hold_left = hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d block %0h mask %0h", $time,
                 out_kind, out_released_block, out_received_mask);
      end else begin
        oldest_due = pending_results.pop_front();
        check_field("kind", oldest_due.kind, out_kind);
        check_field("released_block", oldest_due.blk, out_released_block);
        check_field("received_mask", oldest_due.mask, out_received_mask);
        check_field("last", oldest_due.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan_row(STEP_ITEM, OP_FINISH, 32'h0, 6'd0, 1'b1, KIND_END);
    plan_row(STEP_ITEM, OP_ADD, 32'd100, 6'd0, 1'b1, KIND_ACCEPTED);
    plan_row(STEP_ITEM, OP_ADD, 32'd100, 6'd63, 1'b1, KIND_ACCEPTED);
    plan_row(STEP_ITEM, OP_ADD, 32'd100, 6'd63, 1'b1, KIND_ACCEPTED); // duplicate
    plan_row(STEP_ITEM, OP_ADD, 32'd103, 6'd7, 1'b1, KIND_ACCEPTED);
    plan_row(STEP_ITEM, OP_ADD, 32'd101, 6'd0, 1'b1, KIND_ACCEPTED);
    plan_row(STEP_SPB, OP_ADD, 32'd0, 6'd0, 1'b0, KIND_ERROR);        // acts as 1
    plan_row(STEP_ITEM, OP_ADD, 32'd102, 6'd0, 1'b0, KIND_RELEASED);
    plan_row(STEP_ITEM, OP_ADD, 32'd102, 6'd0, 1'b1, KIND_LATE);
    plan_row(STEP_ITEM, OP_ADD, 32'd104, 6'd1, 1'b1, KIND_ERROR);     // subband range
    plan_row(STEP_SPB, OP_ADD, 32'd127, 6'd0, 1'b0, KIND_ERROR);      // acts as 64
    plan_row(STEP_MIF, OP_ADD, 32'd1, 6'd0, 1'b0, KIND_ERROR);
    plan_row(STEP_ITEM, OP_ADD, 32'd110, 6'd3, 1'b0, KIND_RELEASED);
    plan_row(STEP_ITEM, OP_ADD, 32'd111, 6'd4, 1'b0, KIND_RELEASED);
    plan_row(STEP_MIF, OP_ADD, 32'd0, 6'd0, 1'b0, KIND_ERROR);        // no-drop
    plan_row(STEP_ITEM, OP_ADD, 32'd105, 6'd0, 1'b1, KIND_ERROR);     // late, no-drop
    for (int b = 120; b < 127; b++)
      plan_row(STEP_ITEM, OP_ADD, b, 6'(b - 100), 1'b1, KIND_ACCEPTED);
    plan_row(STEP_ITEM, OP_ADD, 32'd127, 6'd0, 1'b1, KIND_ERROR);     // table full
    plan_row(STEP_MIF, OP_ADD, 32'd3, 6'd0, 1'b0, KIND_ERROR);        // lowered limit
    plan_row(STEP_ITEM, OP_ADD, 32'd130, 6'd0, 1'b0, KIND_RELEASED);
    plan_row(STEP_ITEM, OP_FINISH, 32'hFFFF_FFFF, 6'd63, 1'b0, KIND_END);

    foreach (plan[i]) begin
      case (plan[i].step)
        STEP_ITEM: send(plan[i].op, plan[i].blk, plan[i].sb, plan[i].pinned, plan[i].kind);
        STEP_SPB: begin
          settle();
          write_reg(CFG_SPB, plan[i].blk[CFG_DATA_W-1:0]);
        end
        default: begin
          settle();
          write_reg(CFG_MIF, plan[i].blk[CFG_DATA_W-1:0]);
        end
      endcase
    end

    run_phase(0, 0, 7'd4, 7'd8, 50);
    run_phase(83, 0, 7'd3, 7'd2, 25);
    settle();
    random_items(25);
    run_phase(0, 83, 7'd8, 7'd0, 50);
    run_phase(32, 32, 7'd5, 7'h7F, 50);
    settle();
    hold_requests++;
    run_phase(0, 0, 7'd2, 7'h54, 50);

    // top of the block number range, then everything after it is late
    settle();
    next_blk = 32'hFFFF_FFF0;
    run_phase(32, 32, 7'd2, 7'd8, 30);
    send(OP_ADD, 32'hFFFF_FFFF, 6'd0, 1'b0, KIND_ACCEPTED);
    send(OP_FINISH, 32'h0, 6'd0, 1'b0, KIND_END);
    random_items(12);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
